### sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and codes for the SHA-256 stream hasher: the queued work
// item passed from the front end to the engine, and the digest word item.
// ----------------------------------------------------------------------------
package sha_pkg;

    // Work item kinds; items with no byte and no end mark never get queued
    localparam logic [1:0] OP_BYTE     = 2'd1;
    localparam logic [1:0] OP_END      = 2'd2;
    localparam logic [1:0] OP_BYTE_END = 2'd3;

    // One queued work item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } sha_op_t;

    // One digest word item
    typedef struct packed {
        logic        last;
        logic [31:0] word;
    } sha_out_t;

endpackage

### sv/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 over a byte stream, digest out as eight 32-bit words.
// ----------------------------------------------------------------------------
// Input queue: drive data_byte/byte_present/message_end with push; an item
// is taken on a clock edge with push high and full low. An item with
// message_end high closes the message; byte_present low lets that item
// carry no byte. Items with neither bit set are taken and ignored.
// Output queue: while empty is low, digest_word/word_last show the oldest
// word; pop takes it. Eight words per message, H0 first, word_last on H7.
// The engine takes byte items from the queue while idle; every 64th byte
// starts a compression (one round per cycle through a single round unit,
// then the hash update), during which no items are taken. Finishing
// takes the padding bytes, one or two compressions and the output of the
// eight digest words. A short input queue lets the sender run ahead.
// Reset clears both queues and loads the initial hash values. If the
// receiver stalls, the output queue fills, the engine waits, and full
// rises once the input queue fills in turn.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core
    import sha_pkg::*;
#(
    parameter int IN_DEPTH  = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        message_end,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic        word_last
);

    sha_op_t  q_item;
    logic     q_empty;
    logic     q_pop;
    logic     o_full;
    logic     o_wr;
    sha_out_t o_item;
    sha_out_t o_head;

    sha_front #(
        .QDEPTH (IN_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .message_end  (message_end),
        .q_pop        (q_pop),
        .q_item       (q_item),
        .q_empty      (q_empty)
    );

    sha_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_item  (q_item),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .o_full  (o_full),
        .o_wr    (o_wr),
        .o_item  (o_item)
    );

    // Digest word queue
    sha_fifo #(
        .WIDTH ($bits(sha_out_t)),
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (o_wr),
        .wr_data (o_item),
        .full    (o_full),
        .rd_en   (pop),
        .rd_data (o_head),
        .empty   (empty)
    );

    assign digest_word = o_head.word;
    assign word_last   = o_head.last;

    // Engine only takes work that is queued
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("engine popped an empty work queue");

    // Engine only writes digest words when there is room
    a_wr_room: assert property (@(posedge clk) disable iff (!rst_n)
        o_wr |-> !o_full)
        else $error("digest word written into a full queue");

    // After the last digest word the engine goes back to taking work
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (o_wr && o_item.last) |=> !o_wr)
        else $error("digest word written after the last one");

endmodule

### sv/sha_fifo.sv
// ----------------------------------------------------------------------------
// sha_fifo
// Small register FIFO with full/empty flags, used for the work queue and
// the digest word queue.
// ----------------------------------------------------------------------------
module sha_fifo #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Pointer and count update
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

### sv/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// Input side: accepts items, sorts them into byte / end / byte+end work
// and queues them for the engine. Empty items are accepted and dropped.
// ----------------------------------------------------------------------------
module sha_front
    import sha_pkg::*;
#(
    parameter int QDEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       byte_present,
    input  logic       message_end,
    input  logic       q_pop,
    output sha_op_t    q_item,
    output logic       q_empty
);

    sha_op_t item;
    logic    enq;

    // Classify: kind bit 0 is the byte, bit 1 the end mark
    always_comb
    begin
        item.kind = {message_end, byte_present};
        item.data = data_byte;
    end

    // Only items that carry work go into the queue
    assign enq = push && (item.kind inside {OP_BYTE, OP_END, OP_BYTE_END});

    sha_fifo #(
        .WIDTH ($bits(sha_op_t)),
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (enq),
        .wr_data (item),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_item),
        .empty   (q_empty)
    );

endmodule

### sv/sha_engine.sv
// ----------------------------------------------------------------------------
// sha_engine
// Back end: shifts bytes into the 512-bit block, runs one SHA-256 round per
// cycle, pads the final block byte by byte and emits the digest words.
// ----------------------------------------------------------------------------
module sha_engine
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sha_op_t  q_item,
    input  logic     q_empty,
    output logic     q_pop,
    input  logic     o_full,
    output logic     o_wr,
    output sha_out_t o_item
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ROUND  = 3'd1;
    localparam logic [2:0] ST_ADD    = 3'd2;
    localparam logic [2:0] ST_PAD80  = 3'd3;
    localparam logic [2:0] ST_PADZ   = 3'd4;
    localparam logic [2:0] ST_PADLEN = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    // Control state
    logic [2:0]  state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    logic        fin_reg, fin_next;
    logic        pad_reg, pad_next;
    logic        lend_reg, lend_next;
    logic [31:0] h_reg [8];
    logic [31:0] h_next [8];

    // Datapath
    logic [511:0] blk_reg, blk_next;
    logic [63:0]  len_reg, len_next;
    logic [31:0]  v_reg [8];
    logic [31:0]  v_next [8];

    logic [6:0]  cnt_inc;
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] t1, t2, ch, maj;

    assign cnt_inc = cnt_reg + 7'd1;
    assign w0      = blk_reg[511:480];
    assign w1      = blk_reg[479:448];
    assign w9      = blk_reg[223:192];
    assign w14     = blk_reg[63:32];
    assign w_new   = ssig1(w14) + w9 + ssig0(w1) + w0;
    assign ch      = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj     = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1      = v_reg[7] + bsig1(v_reg[4]) + ch + ROUND_K[rnd_reg] + w0;
    assign t2      = bsig0(v_reg[0]) + maj;

    assign o_item.word = h_reg[idx_reg];
    assign o_item.last = (idx_reg == 3'd7);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        pad_next   = pad_reg;
        lend_next  = lend_reg;
        h_next     = h_reg;
        blk_next   = blk_reg;
        len_next   = len_reg;
        v_next     = v_reg;
        q_pop      = 1'b0;
        o_wr       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_item.kind[0])
                    begin
                        blk_next = {blk_reg[503:0], q_item.data};
                        cnt_next = cnt_inc;
                    end
                    if (q_item.kind[1])
                    begin
                        fin_next  = 1'b1;
                        pad_next  = 1'b0;
                        lend_next = 1'b0;
                        len_next  = bits_reg + {54'd0, cnt_next, 3'd0};
                    end
                    if (cnt_next == 7'd64)
                    begin
                        bits_next  = bits_reg + 64'd512;
                        v_next     = h_reg;
                        rnd_next   = '0;
                        state_next = ST_ROUND;
                    end
                    else if (q_item.kind[1])
                    begin
                        state_next = ST_PAD80;
                    end
                end
            end

            ST_ROUND:
            begin
                blk_next  = {blk_reg[479:0], w_new};
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                cnt_next = '0;
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (lend_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PADZ;
                end
                else
                begin
                    state_next = ST_PAD80;
                end
            end

            ST_PAD80, ST_PADZ:
            begin
                // Marker byte first, then zeros up to the length field
                blk_next = {blk_reg[503:0], (state_reg == ST_PAD80) ? 8'h80 : 8'h00};
                pad_next = 1'b1;
                cnt_next = cnt_inc;
                if (cnt_inc == 7'd64)
                begin
                    v_next     = h_reg;
                    rnd_next   = '0;
                    state_next = ST_ROUND;
                end
                else if (cnt_inc == 7'd56)
                begin
                    rnd_next   = '0;
                    state_next = ST_PADLEN;
                end
                else
                begin
                    state_next = ST_PADZ;
                end
            end

            ST_PADLEN:
            begin
                // Bit length, most significant byte first
                blk_next = {blk_reg[503:0], len_reg[63:56]};
                len_next = {len_reg[55:0], 8'd0};
                cnt_next = cnt_inc;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd7)
                begin
                    lend_next  = 1'b1;
                    v_next     = h_reg;
                    rnd_next   = '0;
                    state_next = ST_ROUND;
                end
            end

            ST_OUT:
            begin
                if (!o_full)
                begin
                    o_wr     = 1'b1;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        h_next     = INIT_H;
                        bits_next  = '0;
                        cnt_next   = '0;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            bits_reg  <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            lend_reg  <= 1'b0;
            h_reg     <= INIT_H;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bits_reg  <= bits_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
            pad_reg   <= pad_next;
            lend_reg  <= lend_next;
            h_reg     <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        len_reg <= len_next;
        v_reg   <= v_next;
    end

endmodule

### sim/tb_sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher_core
// Streams byte items into the hasher, predicts each digest with a local
// SHA-256 model and checks every digest word as it is popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_core;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        message_end;
    logic        empty;
    logic        pop;
    logic [31:0] digest_word;
    logic        word_last;

    sha256_stream_hasher_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .message_end  (message_end),
        .empty        (empty),
        .pop          (pop),
        .digest_word  (digest_word),
        .word_last    (word_last)
    );

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } digest_item_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] INIT_H [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    // Predictor state
    logic [31:0]  hash_h [8];
    logic [7:0]   blk_buf [64];
    int unsigned  blk_fill;
    logic [63:0]  msg_bits;

    digest_item_t digest_q [$];
    int           errors;
    bit           tx_idle_en;
    bit           rx_idle_en;
    bit           rx_hold;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One SHA-256 compression of blk_buf into hash_h
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        for (int i = 0; i < 8; i++)
            v[i] = hash_h[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_h[i] = hash_h[i] + v[i];
    endtask

    task automatic hasher_reset();
        for (int i = 0; i < 8; i++)
            hash_h[i] = INIT_H[i];
        for (int i = 0; i < 64; i++)
            blk_buf[i] = 8'h00;
        blk_fill = 0;
        msg_bits = 64'd0;
    endtask

    // Predict the digest words caused by one accepted item
    task automatic predict_item(input logic [7:0] b, input logic bp, input logic me);
        digest_item_t d;
        if (bp)
        begin
            blk_buf[blk_fill] = b;
            blk_fill++;
            if (blk_fill == 64)
            begin
                compress_block();
                msg_bits += 64'd512;
                blk_fill = 0;
            end
        end
        if (me)
        begin
            msg_bits += 64'(blk_fill * 8);
            blk_buf[blk_fill] = 8'h80;
            for (int i = blk_fill + 1; i < 64; i++)
                blk_buf[i] = 8'h00;
            if (blk_fill >= 56)
            begin
                compress_block();
                for (int i = 0; i < 56; i++)
                    blk_buf[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                blk_buf[63-i] = msg_bits[8*i +: 8];
            compress_block();
            for (int i = 0; i < 8; i++)
            begin
                d.word = hash_h[i];
                d.last = (i == 7);
                digest_q.push_back(d);
            end
            hasher_reset();
        end
    endtask

    // Send one item, with random idle cycles ahead of it; push stays high
    // after the accept so items can follow back to back
    task automatic send_item(input logic [7:0] b, input logic bp, input logic me);
        while (tx_idle_en && $urandom_range(99) < 35)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        data_byte    <= b;
        byte_present <= bp;
        message_end  <= me;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_item(b, bp, me);
    endtask

    task automatic wait_drain();
        while (digest_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom), 1'b1, 1'b0);
        send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Directed: empty message, short texts, null items
    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h55, 1'b0, 1'b0);
        send_item(8'haa, 1'b0, 1'b1);
        push <= 1'b0;
        wait_drain();
    endtask

    // Messages around the 55/56/64 byte padding boundaries
    task automatic test_boundaries();
        int lens [3] = '{55, 56, 64};
        foreach (lens[k])
        begin
            for (int i = 0; i < lens[k] - 1; i++)
                send_item(8'($urandom), 1'b1, 1'b0);
            send_item(8'($urandom), 1'b1, 1'b1);
        end
        push <= 1'b0;
        wait_drain();
    endtask

    // Receiver stalls long so the digest word queue fills and backs up the input
    task automatic test_backpressure();
        rx_hold = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                rx_hold = 1'b0;
            end
            begin
                send_message(3);
                send_message(5);
                send_message(20);
                push <= 1'b0;
            end
        join
        wait_drain();
    endtask

    // Random messages, mostly short, with ignored items mixed in
    task automatic test_random();
        int sent;
        int len;
        sent = 0;
        while (sent < 180)
        begin
            if (sent > 60 && sent < 130)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            else
            begin
                tx_idle_en = 1'b1;
                rx_idle_en = 1'b1;
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_item(8'($urandom), 1'b0, 1'b0);
                send_item(8'($urandom), 1'b1, 1'b0);
            end
            if ($urandom_range(1))
                send_item(8'($urandom), 1'b1, 1'b1);
            else
                send_item(8'($urandom), 1'b0, 1'b1);
            sent += len + 1;
        end
        push <= 1'b0;
        wait_drain();
    endtask

    // Receiver: random pops, plus a long hold when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= !rx_hold && !(rx_idle_en && $urandom_range(99) < 35);
    end

    // Result checker
    always @(posedge clk)
    begin
        digest_item_t exp_d;
        if (rst_n && pop && !empty)
        begin
            if (digest_q.size() == 0)
            begin
                $display("%0t: unexpected digest word %h", $time, digest_word);
                errors++;
            end
            else
            begin
                exp_d = digest_q.pop_front();
                if (digest_word !== exp_d.word)
                begin
                    $display("%0t: digest_word expected %h actual %h",
                             $time, exp_d.word, digest_word);
                    errors++;
                end
                if (word_last !== exp_d.last)
                begin
                    $display("%0t: word_last expected %b actual %b",
                             $time, exp_d.last, word_last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors       = 0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        rx_hold      = 1'b0;
        rst_n        = 1'b0;
        push         = 1'b0;
        data_byte    = 8'h00;
        byte_present = 1'b0;
        message_end  = 1'b0;
        hasher_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_boundaries();
        test_backpressure();
        test_random();
        repeat (300) @(posedge clk);
        if (errors == 0 && digest_q.size() == 0)
            $display("PASS sha256_stream_hasher_core");
        else
            $display("FAIL sha256_stream_hasher_core");
        $finish;
    end

    // Timeout
    initial
    begin
        #20ms;
        $display("FAIL sha256_stream_hasher_core");
        $finish;
    end

endmodule

### filelist.f
sv/sha_pkg.sv
sv/sha_fifo.sv
sv/sha_front.sv
sv/sha_engine.sv
sv/sha256_stream_hasher_core.sv
sim/tb_sha256_stream_hasher_core.sv
